### src/wpt_pkg.sv
// Package: payload structs, status codes and chain link type for the pair tracker.
`timescale 1ns / 1ps
package wpt_pkg;

	// Bytes after the MAC header that a message 2 must at least carry
	localparam int unsigned LLC_BYTES     = 8;
	localparam int unsigned LLC_QOS_BYTES = 10;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNKNOWN = 3'd1,
		ST_LOCKED  = 3'd2,
		ST_MSG4    = 3'd3,
		ST_SHORT   = 3'd4,
		ST_FULL    = 3'd5,
		ST_DUP     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		HIT_NONE   = 2'd0,
		HIT_LIKELY = 2'd1,
		HIT_CONF   = 2'd2
	} hit_t;

	localparam logic OP_BEACON = 1'b0;
	localparam logic OP_KEY    = 1'b1;

	typedef struct packed {
		logic        op;
		logic [47:0] ap_addr;
		logic [63:0] name_tag;
		logic        key_ack;
		logic        key_secure;
		logic        key_install;
		logic [63:0] replay_count;
		logic [15:0] frame_length;
		logic        qos;
	} req_t;

	typedef struct packed {
		logic [1:0] hit_kind;
		logic [7:0] entry_index;
		logic [2:0] status;
	} rsp_t;

	// Word handed from cell to cell, one hop per cycle
	typedef struct packed {
		logic        vld;
		logic        op;
		logic [47:0] addr;
		logic [63:0] tag;
		logic        ack;
		logic        secure;
		logic        install;
		logic [63:0] replay;
		logic        short_frm;
		logic        done;
		logic        added;
		hit_t        hit;
		logic [7:0]  idx;
		status_t     st;
	} link_t;

endpackage

### src/wpt_cell.sv
// One table entry: holds its key and handshake state, serves the word passing by.
`timescale 1ns / 1ps
module wpt_cell
	import wpt_pkg::*;
#(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] count,
	input  link_t         lin,
	output link_t         lout
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);
	localparam logic [7:0]    IDX8   = 8'(IDX);

	logic [47:0] addr_q;
	logic [63:0] tag_q;
	logic        conf_q;
	logic        hf_q;
	logic [63:0] fr_q;
	logic        hs_q;
	logic [63:0] sr_q;
	logic        vld_q;
	link_t       dat_q;

	logic  live;
	logic  empty_first;
	logic  addr_eq;
	logic  act;
	link_t nxt;

	assign live        = MY_IDX < count;
	assign empty_first = MY_IDX == count;
	assign addr_eq     = addr_q == lin.addr;
	assign act         = lin.vld && !lin.done;

	// Decide what this cell does with the passing word
	always_comb begin
		nxt = lin;
		if (act) begin
			if (lin.op == OP_BEACON) begin
				if (live && addr_eq && tag_q == lin.tag) begin
					nxt.done = 1'b1;
					nxt.idx  = IDX8;
					nxt.st   = ST_DUP;
				end else if (empty_first) begin
					nxt.done  = 1'b1;
					nxt.added = 1'b1;
					nxt.idx   = IDX8;
					nxt.st    = ST_OK;
				end
			end else if (live && addr_eq) begin
				nxt.done = 1'b1;
				nxt.idx  = IDX8;
				if (conf_q)
					nxt.st = ST_LOCKED;
				else if (!lin.ack && lin.secure)
					nxt.st = ST_MSG4;
				else if (!lin.ack && lin.short_frm)
					nxt.st = ST_SHORT;
				else begin
					nxt.st = ST_OK;
					if (!lin.ack && hf_q && fr_q == lin.replay)
						nxt.hit = HIT_LIKELY;
					else if (lin.ack && lin.install && hs_q && (sr_q + 64'd1) == lin.replay)
						nxt.hit = HIT_CONF;
				end
			end
		end
	end

	// Link register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else
			vld_q <= lin.vld;
	end

	always_ff @(posedge clk) begin
		dat_q <= nxt;
	end

	// Entry state update
	always_ff @(posedge clk) begin
		if (act && nxt.done) begin
			if (nxt.added) begin
				addr_q <= lin.addr;
				tag_q  <= lin.tag;
				conf_q <= 1'b0;
				hf_q   <= 1'b0;
				fr_q   <= '0;
				hs_q   <= 1'b0;
				sr_q   <= '0;
			end else if (lin.op == OP_KEY && nxt.st == ST_OK) begin
				if (!lin.ack) begin
					sr_q <= lin.replay;
					hs_q <= 1'b1;
					hf_q <= 1'b0;
				end else if (lin.install) begin
					hf_q <= 1'b0;
					hs_q <= 1'b0;
					if (nxt.hit == HIT_CONF)
						conf_q <= 1'b1;
				end else begin
					fr_q <= lin.replay;
					hf_q <= 1'b1;
					hs_q <= 1'b0;
				end
			end
		end
	end

	// Outgoing word: valid from the reset register, data from the plain one
	always_comb begin
		lout     = dat_q;
		lout.vld = vld_q;
	end

endmodule

### src/wpa_handshake_pair_tracker.sv
// Top level: request entry, chain of entry cells, result strobe and entry count.
// The accepted word passes through the link register of every cell before strobe carries the result.
// A new word is taken only once the last one has left the chain; the word walks the cell chain one hop a cycle.
// busy is high from the accept edge until the result edge; start is ignored meanwhile.
// Reset (arst_n low, asynchronous) empties the table and clears the chain valids.
// The result stands for one cycle on strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
module wpa_handshake_pair_tracker
	import wpt_pkg::*;
#(
	parameter int unsigned ENTRIES      = 256,
	parameter int unsigned HEADER_BYTES = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output rsp_t result
);

	localparam int unsigned CW = $clog2(ENTRIES + 1);

	logic [CW-1:0] count_q;
	logic          busy_q;
	logic          accept;
	logic [15:0]   min_len;
	link_t         head;
	link_t         links [ENTRIES+1];
	link_t         tail;

	assign accept  = start && !busy_q;
	assign min_len = 16'(HEADER_BYTES + (req.qos ? LLC_QOS_BYTES : LLC_BYTES));

	// Chain head: build the word from the request
	always_comb begin
		head           = '0;
		head.vld       = accept;
		head.op        = req.op;
		head.addr      = req.ap_addr;
		head.tag       = req.name_tag;
		head.ack       = req.key_ack;
		head.secure    = req.key_secure;
		head.install   = req.key_install;
		head.replay    = req.replay_count;
		head.short_frm = req.frame_length < min_len;
		head.hit       = HIT_NONE;
		head.st        = ST_OK;
	end

	assign links[0] = head;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		wpt_cell #(
			.IDX(g),
			.CW (CW)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.count (count_q),
			.lin   (links[g]),
			.lout  (links[g+1])
		);
	end

	assign tail = links[ENTRIES];

	// Busy flag and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (tail.vld)
				busy_q <= 1'b0;
			if (tail.vld && tail.done && tail.added)
				count_q <= count_q + CW'(1);
		end
	end

	// Result: a word nobody claimed is an unknown address or a full table
	always_comb begin
		result.hit_kind    = tail.hit;
		result.entry_index = tail.idx;
		result.status      = tail.st;
		if (!tail.done) begin
			result.hit_kind    = HIT_NONE;
			result.entry_index = '0;
			result.status      = (tail.op == OP_BEACON) ? ST_FULL : ST_UNKNOWN;
		end
	end

	assign strobe = tail.vld;
	assign busy   = busy_q;

`ifndef SYNTHESIS
	a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !busy)
		else $error("busy still high after result");
	a_strobe_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result without a word in flight");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count beyond table size");
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.hit_kind != HIT_NONE |-> result.status == ST_OK)
		else $error("hit reported with non-accepted status");
`endif

endmodule
